>>> hdl/text_console_char_writer_core_assert.svh
// Assertion macros used by the text console writer checker.
// Needs a clk and rst in the scope where the macros are used.
`ifndef TEXT_CONSOLE_CHAR_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/tccw_pkg.sv
// Shared types and constants for the text console character writer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int INDEX_W = 11;

  localparam logic [7:0] CODE_TAB     = 8'd9;
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_SPACE   = 8'd32;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_CURSOR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_GLYPH,
    OP_TAB,
    OP_NEWLINE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] code;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_TAB,
    ST_SCROLL,
    ST_CURSOR
  } back_state_t;

endpackage

>>> hdl/tccw_front.sv
// Front end: accepts character beats, classifies them and queues commands.
// Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_front
  import tccw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  cmd_t       queue_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       classified;
  logic       push;
  logic       pop;

  always_comb begin
    classified.code = char_code;
    unique case (char_code)
      CODE_NEWLINE: classified.op = OP_NEWLINE;
      CODE_TAB:     classified.op = OP_TAB;
      default:      classified.op = OP_GLYPH;
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = queue_mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> hdl/tccw_back.sv
// Back end: keeps the cursor and turns queued commands into result beats.
// Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_back
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [INDEX_W-1:0] cell_index,
  output logic [7:0]         glyph,
  output logic               last
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);

  back_state_t        state, state_next;
  logic [COL_W-1:0]   column, column_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [INDEX_W-1:0] row_base, row_base_next;
  logic [7:0]         held_glyph, held_glyph_next;

  logic               emit;
  logic               col_last;
  logic [COL_W-1:0]   col_inc;
  logic [INDEX_W-1:0] cur_index;
  back_state_t        line_state;
  logic [ROW_W-1:0]   line_row;
  logic [INDEX_W-1:0] line_base;
  back_state_t        disp_state;
  logic [COL_W-1:0]   disp_column;
  logic [ROW_W-1:0]   disp_row;
  logic [INDEX_W-1:0] disp_base;

  logic               o_load;
  kind_t              o_kind;
  logic [INDEX_W-1:0] o_index;
  logic [7:0]         o_glyph;
  logic               o_last;

  assign emit      = !out_valid || out_ready;
  assign col_last  = (column == COL_W'(COLUMNS - 1));
  assign col_inc   = column + COL_W'(1);
  assign cur_index = row_base + INDEX_W'(column);

  // Moving to the next line either scrolls on the bottom row or steps down.
  always_comb begin
    if (row == ROW_W'(ROWS - 1)) begin
      line_state = ST_SCROLL;
      line_row   = row;
      line_base  = row_base;
    end else begin
      line_state = ST_CURSOR;
      line_row   = row + ROW_W'(1);
      line_base  = row_base + INDEX_W'(COLUMNS);
    end
  end

  always_comb begin
    disp_column = column;
    disp_row    = row;
    disp_base   = row_base;
    unique case (cmd.op)
      OP_GLYPH: disp_state = ST_WRITE;
      OP_TAB:   disp_state = (column[2:0] == 3'd0) ? ST_CURSOR : ST_TAB;
      OP_NEWLINE: begin
        disp_state  = line_state;
        disp_column = '0;
        disp_row    = line_row;
        disp_base   = line_base;
      end
      default:  disp_state = ST_CURSOR;
    endcase
  end

  always_comb begin
    state_next      = state;
    column_next     = column;
    row_next        = row;
    row_base_next   = row_base;
    held_glyph_next = held_glyph;
    cmd_ready       = 1'b0;
    o_load          = 1'b0;
    o_kind          = KIND_WRITE;
    o_index         = cur_index;
    o_glyph         = 8'd0;
    o_last          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          state_next      = disp_state;
          column_next     = disp_column;
          row_next        = disp_row;
          row_base_next   = disp_base;
          held_glyph_next = cmd.code;
        end
      end
      ST_WRITE, ST_TAB: begin
        if (emit) begin
          o_load  = 1'b1;
          o_kind  = KIND_WRITE;
          o_glyph = (state == ST_TAB) ? CODE_SPACE : held_glyph;
          if (col_last) begin
            column_next   = '0;
            row_next      = line_row;
            row_base_next = line_base;
            state_next    = line_state;
          end else begin
            column_next = col_inc;
            if (state == ST_WRITE || col_inc[2:0] == 3'd0) begin
              state_next = ST_CURSOR;
            end
          end
        end
      end
      ST_SCROLL: begin
        if (emit) begin
          o_load     = 1'b1;
          o_kind     = KIND_SCROLL;
          o_index    = '0;
          state_next = ST_CURSOR;
        end
      end
      ST_CURSOR: begin
        if (emit) begin
          o_load    = 1'b1;
          o_kind    = KIND_CURSOR;
          o_last    = 1'b1;
          cmd_ready = 1'b1;
          if (cmd_valid) begin
            state_next      = disp_state;
            column_next     = disp_column;
            row_next        = disp_row;
            row_base_next   = disp_base;
            held_glyph_next = cmd.code;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      column    <= '0;
      row       <= '0;
      row_base  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      column   <= column_next;
      row      <= row_next;
      row_base <= row_base_next;
      if (o_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_glyph <= held_glyph_next;
    if (o_load) begin
      kind       <= o_kind;
      cell_index <= o_index;
      glyph      <= o_glyph;
      last       <= o_last;
    end
  end

endmodule

>>> hdl/text_console_char_writer_core.sv
// An input beat goes through the command queue, back-end state and output registers.
// Throughput: one result per cycle while out_ready is high. A glyph gives write+cursor,
// a newline cursor, a tab one write per space plus cursor, and a scroll adds a result.
// A two-entry command queue lets the input keep accepting while results stall.
// Reset clears the cursor to column 0, row 0 and empties the queue and output stage.
`timescale 1ns / 1ps

module text_console_char_writer_core
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [INDEX_W-1:0] cell_index,
  output logic [7:0]         glyph,
  output logic               last
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  tccw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  tccw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .cell_index (cell_index),
    .glyph      (glyph),
    .last       (last)
  );

endmodule

>>> hdl/tccw_checker.sv
// Port-level checker for the text console writer, bound to the top level.
// Depends on tccw_pkg and text_console_char_writer_core_assert.svh.
`timescale 1ns / 1ps
`include "text_console_char_writer_core_assert.svh"

module tccw_checker
  import tccw_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         char_code,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         kind,
  input logic [INDEX_W-1:0] cell_index,
  input logic [7:0]         glyph,
  input logic               last
);

  `TCCW_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
    in_valid && $stable(char_code), "input beat changed while stalled")
  `TCCW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(kind) && $stable(cell_index) && $stable(glyph) && $stable(last),
    "output beat changed while stalled")
  `TCCW_ASSERT_NOW(a_last_on_cursor, out_valid, last == (kind == KIND_CURSOR),
    "last flag does not match cursor beat")
  `TCCW_ASSERT_NOW(a_scroll_clean, out_valid && kind == KIND_SCROLL,
    cell_index == '0 && glyph == 8'd0, "scroll beat carries index or glyph")
  `TCCW_ASSERT_NEXT(a_scroll_then_cursor, out_valid && out_ready && kind == KIND_SCROLL,
    !out_valid || kind == KIND_CURSOR, "scroll not followed by cursor beat")

endmodule

bind text_console_char_writer_core tccw_checker u_checker (.*);
